// ----- rtl/tets_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tets_pkg
// Shared types, widths and helpers of the timed event table scheduler.
// ----------------------------------------------------------------------------
package tets_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 16;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned MS_W     = 32;
  localparam int unsigned RATE_W   = 20;
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned DELAY_W  = 48;
  localparam int unsigned STATUS_W = 3;

  localparam logic [RATE_W-1:0] RATE_RESET = 20'd100000;

  // status bit positions
  localparam int unsigned ST_ACTIVE = 0;
  localparam int unsigned ST_REPEAT = 1;
  localparam int unsigned ST_PAUSED = 2;

  // divide by one thousand, one radix-16 digit per cycle
  localparam int unsigned MS_PER_S = 1000;
  localparam int unsigned PROD_W   = MS_W + RATE_W;
  localparam int unsigned DIG_W    = 4;
  localparam int unsigned DIG_N    = PROD_W / DIG_W;
  localparam int unsigned REM_W    = $clog2(MS_PER_S);
  localparam int unsigned ACC_W    = REM_W + DIG_W;

  // stream packing
  localparam int unsigned IN_FIELDS_W  = SLOT_W + MS_W + 1;
  localparam int unsigned IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = SLOT_W + 1 + TIME_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  localparam logic KIND_FIRED = 1'b0;
  localparam logic KIND_CLOSE = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK   = 3'd0,
    MODE_CREATE = 3'd1,
    MODE_PAUSE  = 3'd2,
    MODE_RESUME = 3'd3,
    MODE_KILL   = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SLOT_RD,
    S_SLOT_WB,
    S_DIV_WAIT,
    S_CR_WR,
    S_FINAL,
    S_CLOSE
  } seq_state_e;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TIME_W-1:0]   due;
    logic [DELAY_W-1:0]  delay;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] slot;
    logic              err;
    logic [TIME_W-1:0] due;
    logic              last;
  } res_t;

  typedef struct packed {
    logic              start;
    logic [MS_W-1:0]   ms;
    logic [RATE_W-1:0] rate;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DELAY_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [ACC_W-1:0] ms_mult(input logic [DIG_W-1:0] k);
    return ACC_W'(k) * ACC_W'(MS_PER_S);
  endfunction

endpackage

// ----- rtl/tets_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tets_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tets_ram #(
  parameter int unsigned WIDTH = tets_pkg::ENTRY_W,
  parameter int unsigned DEPTH = tets_pkg::SLOT_COUNT_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/tets_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tets_div
// Converts milliseconds to ticks: registered product, then a radix-16
// digit-recurrence divide by one thousand.
// ----------------------------------------------------------------------------
module tets_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tets_pkg::div_req_t req_i,
  output tets_pkg::div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(tets_pkg::DIG_N + 1);

  logic [tets_pkg::PROD_W-1:0] p_q, p_d;
  logic [tets_pkg::REM_W-1:0]  r_q, r_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic                        done_q, done_d;
  logic [tets_pkg::ACC_W-1:0]  acc;
  logic [tets_pkg::DIG_W-1:0]  dig;

  always_comb begin
    acc = {r_q, p_q[tets_pkg::PROD_W-1 -: tets_pkg::DIG_W]};
    dig = '0;
    for (int k = 1; k < 2 ** tets_pkg::DIG_W; k++) begin
      if (acc >= tets_pkg::ms_mult(tets_pkg::DIG_W'(k))) begin
        dig = tets_pkg::DIG_W'(k);
      end
    end
  end

  always_comb begin
    p_d    = p_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    done_d = done_q;
    if (req_i.start) begin
      p_d    = tets_pkg::PROD_W'(req_i.ms) * tets_pkg::PROD_W'(req_i.rate);
      r_d    = '0;
      cnt_d  = CNT_W'(tets_pkg::DIG_N);
      done_d = 1'b0;
    end else if (cnt_q != '0) begin
      p_d    = {p_q[tets_pkg::PROD_W-tets_pkg::DIG_W-1:0], dig};
      r_d    = tets_pkg::REM_W'(acc - tets_pkg::ms_mult(dig));
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    r_q <= r_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = tets_pkg::DELAY_W'(p_q);

endmodule

// ----- rtl/tets_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tets_seq
// Command sequencer: slot table scan with read-modify-write through the RAM,
// firing, allocation, earliest-due search and the output register.
// ----------------------------------------------------------------------------
module tets_seq #(
  parameter int unsigned SLOT_COUNT = tets_pkg::SLOT_COUNT_DEF,
  localparam int unsigned IW = $clog2(SLOT_COUNT)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tets_pkg::MODE_W-1:0]   in_mode_i,
  input  logic [tets_pkg::SLOT_W-1:0]   in_slot_i,
  input  logic [tets_pkg::MS_W-1:0]     in_ms_i,
  input  logic                          in_repeat_i,
  input  logic [tets_pkg::RATE_W-1:0]   rate_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tets_pkg::res_t                out_res_o,
  output logic                          ram_we_o,
  output logic [IW-1:0]                 ram_waddr_o,
  output tets_pkg::entry_t              ram_wdata_o,
  output logic                          ram_re_o,
  output logic [IW-1:0]                 ram_raddr_o,
  input  tets_pkg::entry_t              ram_rdata_i,
  output tets_pkg::div_req_t            div_req_o,
  input  tets_pkg::div_rsp_t            div_rsp_i
);

  localparam int unsigned CW = $clog2(SLOT_COUNT + 1);

  tets_pkg::seq_state_e state_q, state_d;

  logic [tets_pkg::MODE_W-1:0]   mode_q, mode_d;
  logic [tets_pkg::SLOT_W-1:0]   idx_q, idx_d;
  logic                          rep_q, rep_d;
  logic [tets_pkg::TIME_W-1:0]   now_q, now_d;
  logic [tets_pkg::TIME_W-1:0]   next_due_q, next_due_d;
  logic [tets_pkg::TIME_W-1:0]   limit_q, limit_d;
  logic                          fire_q, fire_d;
  logic [CW-1:0]                 rd_ptr_q, rd_ptr_d;
  logic                          proc_vld_q, proc_vld_d;
  logic [IW-1:0]                 proc_idx_q, proc_idx_d;
  logic                          rd_vld_q;
  logic [SLOT_COUNT-1:0]         vld_q;
  logic [tets_pkg::TIME_W-1:0]   best_q, best_d;
  logic [tets_pkg::TIME_W-1:0]   cand_q, cand_d;
  logic                          found_q, found_d;
  logic [IW-1:0]                 free_idx_q, free_idx_d;
  logic [tets_pkg::SLOT_W-1:0]   close_slot_q, close_slot_d;
  logic                          close_err_q, close_err_d;
  logic                          out_vld_q, out_vld_d;
  tets_pkg::res_t                out_q, out_d, res_n;
  logic                          out_load;

  logic                          accept, out_free, is_tick, is_create, is_resume;
  logic                          in_bad_idx, hit, take, stall, scan_done;
  logic [tets_pkg::STATUS_W-1:0] cur_st, upd_st, wst;
  logic [tets_pkg::TIME_W-1:0]   upd_due, now_inc, cr_due;
  tets_pkg::entry_t              cur;

  assign in_ready_o = (state_q == tets_pkg::S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_vld_q || out_ready_i;
  assign is_tick    = (mode_q == tets_pkg::MODE_TICK);
  assign is_create  = (mode_q == tets_pkg::MODE_CREATE);
  assign is_resume  = (mode_q == tets_pkg::MODE_RESUME);
  assign in_bad_idx = 32'(in_slot_i) >= 32'(SLOT_COUNT);
  assign now_inc    = now_q + tets_pkg::TIME_W'(1);
  assign cr_due     = now_q + tets_pkg::TIME_W'(div_rsp_i.quot);

  // slot pipeline stage
  assign cur     = ram_rdata_i;
  assign cur_st  = rd_vld_q ? cur.status : '0;
  assign hit     = is_tick && fire_q && cur_st[tets_pkg::ST_ACTIVE] && (cur.due <= limit_q);
  assign upd_st  = (hit && !cur_st[tets_pkg::ST_REPEAT]) ? '0 : cur_st;
  assign upd_due = (hit && cur_st[tets_pkg::ST_REPEAT])
                 ? cur.due + tets_pkg::TIME_W'(cur.delay) : cur.due;
  assign take    = upd_st[tets_pkg::ST_ACTIVE] && (upd_due != '0)
                 && ((best_q == '0) || (upd_due < best_q));
  assign stall   = (state_q == tets_pkg::S_SCAN) && proc_vld_q && hit && !out_free;
  assign scan_done = (state_q == tets_pkg::S_SCAN) && !proc_vld_q
                   && (rd_ptr_q == CW'(SLOT_COUNT));

  assign div_req_o.start = accept && (in_mode_i == tets_pkg::MODE_CREATE);
  assign div_req_o.ms    = in_ms_i;
  assign div_req_o.rate  = rate_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tets_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_mode_i) inside
            tets_pkg::MODE_TICK, tets_pkg::MODE_CREATE: state_d = tets_pkg::S_SCAN;
            tets_pkg::MODE_PAUSE, tets_pkg::MODE_RESUME, tets_pkg::MODE_KILL: begin
              state_d = in_bad_idx ? tets_pkg::S_CLOSE : tets_pkg::S_SLOT_RD;
            end
            default: state_d = tets_pkg::S_CLOSE;
          endcase
        end
      end
      tets_pkg::S_SCAN: begin
        if (scan_done) begin
          if (is_create) begin
            state_d = found_q ? tets_pkg::S_DIV_WAIT : tets_pkg::S_CLOSE;
          end else begin
            state_d = tets_pkg::S_FINAL;
          end
        end
      end
      tets_pkg::S_SLOT_RD:  state_d = tets_pkg::S_SLOT_WB;
      tets_pkg::S_SLOT_WB:  state_d = is_resume ? tets_pkg::S_SCAN : tets_pkg::S_CLOSE;
      tets_pkg::S_DIV_WAIT: if (div_rsp_i.done) state_d = tets_pkg::S_CR_WR;
      tets_pkg::S_CR_WR:    state_d = tets_pkg::S_FINAL;
      tets_pkg::S_FINAL:    state_d = tets_pkg::S_CLOSE;
      tets_pkg::S_CLOSE:    if (out_free) state_d = tets_pkg::S_IDLE;
      default:              state_d = tets_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    mode_d       = mode_q;
    idx_d        = idx_q;
    rep_d        = rep_q;
    now_d        = now_q;
    next_due_d   = next_due_q;
    limit_d      = limit_q;
    fire_d       = fire_q;
    rd_ptr_d     = rd_ptr_q;
    proc_vld_d   = proc_vld_q;
    proc_idx_d   = proc_idx_q;
    best_d       = best_q;
    cand_d       = cand_q;
    found_d      = found_q;
    free_idx_d   = free_idx_q;
    close_slot_d = close_slot_q;
    close_err_d  = close_err_q;
    ram_we_o     = 1'b0;
    ram_waddr_o  = proc_idx_q;
    ram_wdata_o  = cur;
    ram_re_o     = 1'b0;
    ram_raddr_o  = IW'(rd_ptr_q);
    wst          = cur_st;
    out_load     = 1'b0;
    res_n        = '{kind: tets_pkg::KIND_CLOSE, slot: close_slot_q, err: close_err_q,
                     due: next_due_q, last: 1'b1};

    unique case (state_q)
      tets_pkg::S_IDLE: begin
        if (accept) begin
          mode_d       = in_mode_i;
          idx_d        = in_slot_i;
          rep_d        = in_repeat_i;
          rd_ptr_d     = '0;
          proc_vld_d   = 1'b0;
          best_d       = '0;
          cand_d       = '0;
          found_d      = 1'b0;
          close_slot_d = '0;
          close_err_d  = 1'b0;
          limit_d      = next_due_q;
          fire_d       = 1'b0;
          unique case (in_mode_i) inside
            tets_pkg::MODE_TICK: begin
              now_d  = now_inc;
              fire_d = (next_due_q != '0) && (now_inc >= next_due_q);
            end
            tets_pkg::MODE_CREATE: begin
              close_slot_d = '0;
            end
            tets_pkg::MODE_PAUSE, tets_pkg::MODE_RESUME, tets_pkg::MODE_KILL: begin
              close_slot_d = in_slot_i;
              close_err_d  = in_bad_idx;
            end
            default: close_err_d = 1'b1;
          endcase
        end
      end
      tets_pkg::S_SCAN: begin
        if (!stall) begin
          if (rd_ptr_q != CW'(SLOT_COUNT)) begin
            ram_re_o   = 1'b1;
            rd_ptr_d   = rd_ptr_q + CW'(1);
            proc_vld_d = 1'b1;
            proc_idx_d = IW'(rd_ptr_q);
          end else begin
            proc_vld_d = 1'b0;
          end
          if (proc_vld_q) begin
            if (hit) begin
              ram_we_o    = 1'b1;
              ram_wdata_o = '{status: upd_st, due: upd_due, delay: cur.delay};
              out_load    = 1'b1;
              res_n       = '{kind: tets_pkg::KIND_FIRED, slot: tets_pkg::SLOT_W'(proc_idx_q),
                              err: 1'b0, due: '0, last: 1'b0};
            end
            if (take) begin
              best_d = upd_due;
            end
            if (is_create && !found_q && (proc_idx_q != '0) && (cur_st == '0)) begin
              found_d    = 1'b1;
              free_idx_d = proc_idx_q;
            end
          end
        end
        if (scan_done && is_create && !found_q) begin
          close_err_d = 1'b1;
        end
      end
      tets_pkg::S_SLOT_RD: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = IW'(idx_q);
      end
      tets_pkg::S_SLOT_WB: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = IW'(idx_q);
        unique case (mode_q) inside
          tets_pkg::MODE_PAUSE: begin
            wst[tets_pkg::ST_PAUSED] = 1'b1;
            wst[tets_pkg::ST_ACTIVE] = 1'b0;
            ram_wdata_o = '{status: wst, due: cur.due, delay: cur.delay};
          end
          tets_pkg::MODE_RESUME: begin
            wst[tets_pkg::ST_PAUSED] = 1'b0;
            wst[tets_pkg::ST_ACTIVE] = 1'b1;
            ram_wdata_o = '{status: wst, due: now_q + tets_pkg::TIME_W'(cur.delay),
                            delay: cur.delay};
          end
          default: begin
            ram_wdata_o = '{status: '0, due: cur.due, delay: cur.delay};
          end
        endcase
        rd_ptr_d   = '0;
        proc_vld_d = 1'b0;
        best_d     = '0;
      end
      tets_pkg::S_DIV_WAIT: begin
        cand_d = '0;
      end
      tets_pkg::S_CR_WR: begin
        wst                      = '0;
        wst[tets_pkg::ST_ACTIVE] = 1'b1;
        wst[tets_pkg::ST_REPEAT] = rep_q;
        ram_we_o     = 1'b1;
        ram_waddr_o  = free_idx_q;
        ram_wdata_o  = '{status: wst, due: cr_due, delay: div_rsp_i.quot};
        cand_d       = cr_due;
        close_slot_d = tets_pkg::SLOT_W'(free_idx_q);
      end
      tets_pkg::S_FINAL: begin
        next_due_d = ((cand_q != '0) && ((best_q == '0) || (cand_q < best_q)))
                   ? cand_q : best_q;
      end
      tets_pkg::S_CLOSE: begin
        out_load = out_free;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase

    out_vld_d = out_load || (out_vld_q && !out_ready_i);
    out_d     = out_load ? res_n : out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tets_pkg::S_IDLE;
      now_q      <= '0;
      next_due_q <= '0;
      fire_q     <= 1'b0;
      rd_ptr_q   <= '0;
      proc_vld_q <= 1'b0;
      rd_vld_q   <= 1'b0;
      vld_q      <= '0;
      found_q    <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      now_q      <= now_d;
      next_due_q <= next_due_d;
      fire_q     <= fire_d;
      rd_ptr_q   <= rd_ptr_d;
      proc_vld_q <= proc_vld_d;
      found_q    <= found_d;
      out_vld_q  <= out_vld_d;
      if (ram_re_o) begin
        rd_vld_q <= vld_q[ram_raddr_o];
      end
      if (ram_we_o) begin
        vld_q[ram_waddr_o] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    idx_q        <= idx_d;
    rep_q        <= rep_d;
    limit_q      <= limit_d;
    proc_idx_q   <= proc_idx_d;
    best_q       <= best_d;
    cand_q       <= cand_d;
    free_idx_q   <= free_idx_d;
    close_slot_q <= close_slot_d;
    close_err_q  <= close_err_d;
    out_q        <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;

endmodule

// ----- rtl/timed_event_table_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_event_table_scheduler
// Table of timed events with autoreload, kept in one RAM, driven by tick,
// create, pause, resume and kill requests.
//
//   channel | direction | tdata (low bit up)                 | tuser  | tlast
//   s_axis  | in        | slot_index, interval_ms, repeat    | mode   | -
//   m_axis  | out       | slot_out, error_flag, earliest_due | kind   | last
//   cfg     | in        | tick_rate_hz (20 bits)             | -      | -
//
// tick: one entry per cycle through the RAM read port, held while a fired result
// waits on a full output. resume: slot read and write-back, then the scan. create:
// scan beside the divide by one thousand, closing with an error when no slot is
// free. pause, kill: slot read and write-back only; rejected requests go straight
// to the closing result. valid bits clear at reset, no clearing pass; the next
// request is taken once the closing result sits in the output register.
// ----------------------------------------------------------------------------
module timed_event_table_scheduler #(
  parameter int unsigned SLOT_COUNT = tets_pkg::SLOT_COUNT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // slot_index, interval_ms, repeat_flag
  input  logic [tets_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // mode
  input  logic [tets_pkg::MODE_W-1:0]       s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // slot_out, error_flag, earliest_due
  output logic [tets_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // result_kind
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tets_pkg::RATE_W-1:0]       cfg_wdata_i
);

  localparam int unsigned IW = $clog2(SLOT_COUNT);

  logic [tets_pkg::RATE_W-1:0] rate_q;
  logic                        ram_we, ram_re;
  logic [IW-1:0]               ram_waddr, ram_raddr;
  tets_pkg::entry_t            ram_wdata, ram_rdata;
  tets_pkg::div_req_t          div_req;
  tets_pkg::div_rsp_t          div_rsp;
  tets_pkg::res_t              res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= tets_pkg::RATE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      rate_q <= cfg_wdata_i;
    end
  end

  tets_seq #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_mode_i   (s_axis_tuser),
    .in_slot_i   (s_axis_tdata[tets_pkg::SLOT_W-1:0]),
    .in_ms_i     (s_axis_tdata[tets_pkg::SLOT_W +: tets_pkg::MS_W]),
    .in_repeat_i (s_axis_tdata[tets_pkg::SLOT_W + tets_pkg::MS_W]),
    .rate_i      (rate_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );

  tets_ram #(
    .WIDTH (tets_pkg::ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tets_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign m_axis_tdata = {{tets_pkg::OUT_PAD_W{1'b0}}, res.due, res.err, res.slot};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

// ----- rtl/tets_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tets_checker
// Port-level checks of the timed event table scheduler, bound to the top.
// ----------------------------------------------------------------------------
module tets_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [tets_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tuser,
  input logic                            m_axis_tlast
);

  // closing result and only it carries last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser))
    else $error("last flag disagrees with result kind");

  // fired results carry no error and no due time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == tets_pkg::KIND_FIRED))
      |-> (m_axis_tdata[tets_pkg::OUT_DATA_W-1:tets_pkg::SLOT_W] == '0))
    else $error("fired result with error or due time");

  // one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while another is in progress");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind timed_event_table_scheduler tets_checker u_tets_checker (.*);

// ----- dv/tb_timed_event_table_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timed_event_table_scheduler
// Self-checking bench for the timed event table: directed table fill, slot
// commands and bad modes, then random tick-heavy traffic at several tick
// rates, with random gaps and output stalls, checked against a local model.
// ----------------------------------------------------------------------------

class event_table_scoreboard;
  logic [tets_pkg::STATUS_W-1:0] slot_state [tets_pkg::SLOT_COUNT_DEF];
  logic [tets_pkg::TIME_W-1:0]   slot_due   [tets_pkg::SLOT_COUNT_DEF];
  logic [tets_pkg::DELAY_W-1:0]  slot_delay [tets_pkg::SLOT_COUNT_DEF];
  bit                            written    [tets_pkg::SLOT_COUNT_DEF];
  logic [tets_pkg::TIME_W-1:0]   now_ticks;
  logic [tets_pkg::TIME_W-1:0]   next_due;
  logic [tets_pkg::RATE_W-1:0]   tick_rate;
  tets_pkg::res_t                expected_results [$];
  int                            errors;
  int                            requests;
  int                            checked;
  int                            fired;

  function new();
    for (int s = 0; s < tets_pkg::SLOT_COUNT_DEF; s++) begin
      slot_state[s] = '0;
      slot_due[s]   = '0;
      slot_delay[s] = '0;
      written[s]    = 1'b0;
    end
    now_ticks = '0;
    next_due  = '0;
    tick_rate = tets_pkg::RATE_RESET;
    errors    = 0;
    requests  = 0;
    checked   = 0;
    fired     = 0;
  endfunction

  function void find_earliest();
    logic [tets_pkg::TIME_W-1:0] best;
    best = '0;
    for (int s = 0; s < tets_pkg::SLOT_COUNT_DEF; s++) begin
      if (slot_state[s][tets_pkg::ST_ACTIVE] && slot_due[s] != '0) begin
        if (best == '0 || slot_due[s] < best) best = slot_due[s];
      end
    end
    next_due = best;
  endfunction

  function void push_close(logic [tets_pkg::SLOT_W-1:0] slot, logic err);
    expected_results.push_back('{tets_pkg::KIND_CLOSE, slot, err, next_due, 1'b1});
  endfunction

  function void note_request(logic [tets_pkg::MODE_W-1:0] mode,
                             logic [tets_pkg::SLOT_W-1:0] idx,
                             logic [tets_pkg::MS_W-1:0] ms, logic rep);
    logic [tets_pkg::TIME_W-1:0] limit;
    logic [63:0]                 prod;
    int                          free_slot;
    requests++;
    case (mode)
      tets_pkg::MODE_TICK: begin
        now_ticks = now_ticks + 1;
        limit = next_due;
        if (limit != '0 && now_ticks >= limit) begin
          for (int s = 0; s < tets_pkg::SLOT_COUNT_DEF; s++) begin
            if (slot_state[s][tets_pkg::ST_ACTIVE] && slot_due[s] <= limit) begin
              expected_results.push_back('{tets_pkg::KIND_FIRED,
                                           tets_pkg::SLOT_W'(s), 1'b0, '0, 1'b0});
              fired++;
              if (slot_state[s][tets_pkg::ST_REPEAT])
                slot_due[s] = slot_due[s] + tets_pkg::TIME_W'(slot_delay[s]);
              else
                slot_state[s] = '0;
            end
          end
        end
        find_earliest();
        push_close('0, 1'b0);
      end
      tets_pkg::MODE_CREATE: begin
        free_slot = 0;
        for (int s = 1; s < tets_pkg::SLOT_COUNT_DEF; s++) begin
          if (free_slot == 0 && slot_state[s] == '0) free_slot = s;
        end
        if (free_slot == 0) begin
          push_close('0, 1'b1);
        end else begin
          prod = 64'(ms) * 64'(tick_rate);
          slot_delay[free_slot] = tets_pkg::DELAY_W'(prod / 64'(tets_pkg::MS_PER_S));
          slot_due[free_slot] = now_ticks + tets_pkg::TIME_W'(slot_delay[free_slot]);
          slot_state[free_slot] = '0;
          slot_state[free_slot][tets_pkg::ST_ACTIVE] = 1'b1;
          slot_state[free_slot][tets_pkg::ST_REPEAT] = rep;
          written[free_slot] = 1'b1;
          find_earliest();
          push_close(tets_pkg::SLOT_W'(free_slot), 1'b0);
        end
      end
      tets_pkg::MODE_PAUSE, tets_pkg::MODE_RESUME, tets_pkg::MODE_KILL: begin
        if (int'(idx) >= tets_pkg::SLOT_COUNT_DEF) begin
          push_close(idx, 1'b1);
        end else begin
          if (mode == tets_pkg::MODE_PAUSE) begin
            slot_state[idx][tets_pkg::ST_PAUSED] = 1'b1;
            slot_state[idx][tets_pkg::ST_ACTIVE] = 1'b0;
          end else if (mode == tets_pkg::MODE_RESUME) begin
            slot_due[idx] = now_ticks + tets_pkg::TIME_W'(slot_delay[idx]);
            slot_state[idx][tets_pkg::ST_ACTIVE] = 1'b1;
            slot_state[idx][tets_pkg::ST_PAUSED] = 1'b0;
            find_earliest();
          end else begin
            slot_state[idx] = '0;
          end
          push_close(idx, 1'b0);
        end
      end
      default: push_close('0, 1'b1);
    endcase
  endfunction

  function void check_result(tets_pkg::res_t got);
    tets_pkg::res_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result kind %0d slot %0d", got.kind, got.slot);
      errors++;
      return;
    end
    want = expected_results.pop_front();
    checked++;
    if (got.kind !== want.kind) begin
      $error("result_kind expected %0d got %0d", want.kind, got.kind);
      errors++;
    end
    if (got.slot !== want.slot) begin
      $error("slot_out expected %0d got %0d", want.slot, got.slot);
      errors++;
    end
    if (got.err !== want.err) begin
      $error("error_flag expected %0d got %0d", want.err, got.err);
      errors++;
    end
    if (got.due !== want.due) begin
      $error("earliest_due expected %0d got %0d", want.due, got.due);
      errors++;
    end
    if (got.last !== want.last) begin
      $error("last_flag expected %0d got %0d", want.last, got.last);
      errors++;
    end
  endfunction

  function int outstanding();
    return expected_results.size();
  endfunction
endclass

module tb_timed_event_table_scheduler;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = tets_pkg::SLOT_COUNT_DEF + 16;
  localparam int PHASE_REQUESTS = 24;
  localparam logic [tets_pkg::MODE_W-1:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [tets_pkg::MODE_W-1:0] MODE_UNUSED_LAST = 3'd7;
  localparam logic [tets_pkg::RATE_W-1:0] RATE_MIN = 20'd1;
  localparam logic [tets_pkg::RATE_W-1:0] RATE_MS = 20'd1000;
  localparam logic [tets_pkg::RATE_W-1:0] RATE_MAX = 20'd1000000;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              s_axis_tvalid;
  logic                              s_axis_tready;
  logic [tets_pkg::IN_DATA_W-1:0]    s_axis_tdata;
  logic [tets_pkg::MODE_W-1:0]       s_axis_tuser;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready;
  logic [tets_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
  logic                              m_axis_tuser;
  logic                              m_axis_tlast;
  logic                              cfg_valid_i;
  logic                              cfg_ready_o;
  logic [tets_pkg::RATE_W-1:0]       cfg_wdata_i;

  event_table_scoreboard sb;
  bit calm;
  int stall_left;
  int idle_cycles;

  timed_event_table_scheduler uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // output back-pressure
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    tets_pkg::res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind = m_axis_tuser;
      got.slot = m_axis_tdata[tets_pkg::SLOT_W-1:0];
      got.err  = m_axis_tdata[tets_pkg::SLOT_W];
      got.due  = m_axis_tdata[tets_pkg::SLOT_W+1 +: tets_pkg::TIME_W];
      got.last = m_axis_tlast;
      sb.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(logic [tets_pkg::MODE_W-1:0] mode,
                              logic [tets_pkg::SLOT_W-1:0] idx,
                              logic [tets_pkg::MS_W-1:0] ms, logic rep);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= tets_pkg::IN_DATA_W'({rep, ms, idx});
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(mode, idx, ms, rep);
  endtask

  task automatic drain(bit settle);
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_rate(logic [tets_pkg::RATE_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.tick_rate = value;
  endtask

  task automatic random_request(int ms_lo, int ms_hi);
    int roll;
    logic [tets_pkg::SLOT_W-1:0] idx;
    logic [tets_pkg::MS_W-1:0] ms;
    roll = $urandom_range(0, 99);
    idx = tets_pkg::SLOT_W'($urandom_range(0, 15));
    ms = $urandom();
    if (roll < 45) begin
      send_request(tets_pkg::MODE_TICK, idx, ms, 1'($urandom_range(0, 1)));
    end else if (roll < 70) begin
      if ($urandom_range(0, 9) != 0) ms = tets_pkg::MS_W'($urandom_range(ms_lo, ms_hi));
      send_request(tets_pkg::MODE_CREATE, idx, ms, 1'($urandom_range(0, 1)));
    end else if (roll < 78) begin
      send_request(tets_pkg::MODE_PAUSE, idx, ms, 1'b0);
    end else if (roll < 86) begin
      idx = tets_pkg::SLOT_W'($urandom_range(1, 15));
      // a slot whose delay was never set must not be resumed
      if (sb.written[idx])
        send_request(tets_pkg::MODE_RESUME, idx, ms, 1'b1);
      else
        send_request(tets_pkg::MODE_TICK, idx, ms, 1'b1);
    end else if (roll < 96) begin
      send_request(tets_pkg::MODE_KILL, idx, ms, 1'b0);
    end else begin
      send_request(tets_pkg::MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST)),
                   idx, ms, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    logic [tets_pkg::RATE_W-1:0] phase_rate [4];
    int phase_ms_lo [4];
    int phase_ms_hi [4];
    sb = new();
    calm = 1'b0;
    stall_left = 0;
    idle_cycles = 0;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    m_axis_tready <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_wdata_i <= '0;
    phase_rate = '{RATE_MIN, RATE_MS, RATE_MAX, RATE_MS};
    phase_ms_lo = '{1000, 1, 0, 1};
    phase_ms_hi = '{9000, 9, 1, 9};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the table: zero delay at time zero, widest interval, then the rest
    send_request(tets_pkg::MODE_CREATE, '0, '0, 1'b0);
    send_request(tets_pkg::MODE_CREATE, '1, '1, 1'b1);
    for (int i = 0; i < 13; i++)
      send_request(tets_pkg::MODE_CREATE, tets_pkg::SLOT_W'(i),
                   tets_pkg::MS_W'($urandom_range(0, 3)), 1'(i % 2));
    send_request(tets_pkg::MODE_CREATE, '0, 32'd5, 1'b0);
    send_request(MODE_UNUSED_LAST, '1, '1, 1'b1);
    send_request(tets_pkg::MODE_PAUSE, 4'd3, '0, 1'b0);
    send_request(tets_pkg::MODE_TICK, '0, '0, 1'b0);
    send_request(tets_pkg::MODE_RESUME, 4'd3, '0, 1'b0);
    send_request(tets_pkg::MODE_PAUSE, 4'd15, '0, 1'b0);
    send_request(tets_pkg::MODE_KILL, 4'd1, '0, 1'b0);
    send_request(tets_pkg::MODE_KILL, 4'd0, '0, 1'b0);
    send_request(tets_pkg::MODE_TICK, '1, '1, 1'b1);
    send_request(tets_pkg::MODE_RESUME, 4'd15, '0, 1'b0);
    drain(1'b1);

    for (int p = 0; p < 4; p++) begin
      write_rate(phase_rate[p]);
      calm = (p == 1);
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
        if ((p == 0 && i == PHASE_REQUESTS / 2) || $urandom_range(0, 19) == 0)
          drain(1'b0);
        random_request(phase_ms_lo[p], phase_ms_hi[p]);
      end
      drain(1'b1);
    end

    $display("covered %0d requests, %0d results checked, %0d events fired",
             sb.requests, sb.checked, sb.fired);
    $display("tick rates from %0d to %0d per second, table full and bad modes",
             RATE_MIN, RATE_MAX);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
